>>> hdl/csa_pkg.sv
// Shared types and constants for the cave smoothing step core.
// Used by csa_line_cell, csa_result_fifo and cave_smoothing_automaton_step_core.
// Depends on nothing.
`default_nettype none

package csa_pkg;

    localparam int TILE_W = 2;
    typedef logic [TILE_W-1:0] t_tile;

    localparam t_tile TILE_GROUND = 2'd0;
    localparam t_tile TILE_WALL   = 2'd1;
    localparam t_tile TILE_VOID   = 2'd2;

    localparam int OUT_ROW_W  = 12;
    localparam int OUT_COL_W  = 6;
    localparam int CFG_ROWS_W = 13;
    localparam int CFG_COLS_W = 7;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLS = 1'd1;

    localparam logic [CFG_ROWS_W-1:0] CFG_ROWS_RESET = 13'd64;
    localparam logic [CFG_COLS_W-1:0] CFG_COLS_RESET = 7'd64;

    localparam int WALL_CNT_W = 4;
    localparam logic [WALL_CNT_W-1:0] WALL_LIMIT = 4'd4;

    localparam int RES_PER_ITEM = 3;
    localparam int QUEUE_DEPTH  = 8;
    localparam int QUEUE_PTR_W  = 3;
    localparam int QUEUE_CNT_W  = 4;
    localparam int PUSH_N_W     = 2;

    typedef struct packed {
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        t_tile                tile;
        logic                 last;
    } t_result;

    typedef struct packed {
        logic [PUSH_N_W-1:0]            n;
        t_result [RES_PER_ITEM-1:0]     ent;
    } t_push;

    typedef struct packed {
        t_tile older;
        t_tile newer;
    } t_line;

endpackage

`default_nettype wire

>>> hdl/csa_line_cell.sv
// One cell of the line store chain: holds the two stored rows for one column slot.
// Depends on csa_pkg.
`default_nettype none

module csa_line_cell
    import csa_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_shift,
    input  wire logic  i_load,
    input  wire t_line i_prev,
    input  wire t_line i_ins,
    output t_line      o_q
);

    t_line r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_load ? i_ins : i_prev;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

>>> hdl/csa_result_fifo.sv
// Result queue that takes up to three results per cycle and hands out one.
// Depends on csa_pkg.
`default_nettype none

module csa_result_fifo
    import csa_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    input  wire logic  i_pop,
    output logic       o_valid,
    output logic       o_no_room,
    output t_result    o_head
);

    t_result                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  r_wr;
    logic [QUEUE_PTR_W-1:0]  r_rd;
    logic [QUEUE_CNT_W-1:0]  r_cnt;
    logic [QUEUE_CNT_W-1:0]  n_cnt;
    logic                    pop_ok;

    assign pop_ok    = i_pop && (r_cnt != '0);
    assign n_cnt     = r_cnt + QUEUE_CNT_W'(i_push.n) - QUEUE_CNT_W'(pop_ok);
    assign o_valid   = (r_cnt != '0);
    assign o_no_room = (r_cnt > QUEUE_CNT_W'(QUEUE_DEPTH - RES_PER_ITEM));
    assign o_head    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RES_PER_ITEM; k++) begin
            if (PUSH_N_W'(k) < i_push.n) begin
                r_mem[r_wr + QUEUE_PTR_W'(k)] <= i_push.ent[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + QUEUE_PTR_W'(i_push.n);
            r_rd  <= r_rd + QUEUE_PTR_W'(pop_ok);
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

>>> hdl/cave_smoothing_automaton_step_core.sv
// Top level of the cave smoothing step: one smoothing generation on a raster tile stream.
// Results of an accepted tile enter the result queue at that edge and leave it in order.
// Throughput is one tile per cycle, capped by one result out per cycle if i_stall is low;
// a tile causes up to three results and the input stalls while the queue holds over five.
// Reset restores the grid size registers to 64 by 64 and clears counters, window and queue.
// Depends on csa_pkg, csa_line_cell and csa_result_fifo.
`default_nettype none

module cave_smoothing_automaton_step_core
    import csa_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 4096
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [TILE_W-1:0]     i_tile_in,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [OUT_ROW_W-1:0]       o_out_row,
    output logic [OUT_COL_W-1:0]       o_out_col,
    output logic [TILE_W-1:0]          o_tile_out,
    output logic                       o_run_last,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ROW_CMP_W = (CFG_ROWS_W > $clog2(MAX_ROWS + 1)) ? CFG_ROWS_W
                                                                   : $clog2(MAX_ROWS + 1);
    localparam int COL_CMP_W = (CFG_COLS_W > $clog2(MAX_COLS + 1)) ? CFG_COLS_W
                                                                   : $clog2(MAX_COLS + 1);

    typedef logic [2:0][TILE_W-1:0] t_wcol;

    logic [CFG_ROWS_W-1:0] r_grid_rows;
    logic [CFG_COLS_W-1:0] r_grid_cols;
    logic [ROW_W-1:0]      r_row;
    logic [COL_W-1:0]      r_col;
    t_wcol                 r_w1;
    t_wcol                 r_w2;

    logic [ROW_CMP_W-1:0]  rows_ext;
    logic [ROW_CMP_W-1:0]  rows_eff;
    logic [ROW_CMP_W-1:0]  rows_last;
    logic [COL_CMP_W-1:0]  cols_ext;
    logic [COL_CMP_W-1:0]  cols_eff;
    logic [COL_CMP_W-1:0]  cols_last;
    logic [COL_CMP_W-1:0]  ins_pos;
    logic                  row_is_last;
    logic                  col_is_last;
    logic                  in_acc;
    logic                  cfg_wr;
    logic                  no_room;

    t_line                 chain [MAX_COLS];
    t_line                 line_ins;
    logic [MAX_COLS-1:0]   ins_sel;
    t_tile                 up2;
    t_tile                 up1;
    t_tile                 tile_cur;

    t_tile                 nb [8];
    t_tile                 center;
    logic [WALL_CNT_W-1:0] walls;
    logic                  any_void;
    logic                  on_border;
    t_tile                 smooth_tile;

    logic [ROW_W+OUT_ROW_W-1:0] row_wide_cur;
    logic [ROW_W+OUT_ROW_W-1:0] row_wide_m1;
    logic [COL_W+OUT_COL_W-1:0] col_wide_cur;
    logic [COL_W+OUT_COL_W-1:0] col_wide_m1;

    logic                  f1;
    logic                  f2;
    logic                  f3;
    t_result               res1;
    t_result               res2;
    t_result               res3;
    t_push                 push;
    t_result               head;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign in_acc      = i_valid && !o_stall;
    assign o_stall     = no_room;

    always_comb begin
        rows_ext = ROW_CMP_W'(r_grid_rows);
        if (rows_ext == '0) begin
            rows_eff = ROW_CMP_W'(1);
        end else if (rows_ext > ROW_CMP_W'(MAX_ROWS)) begin
            rows_eff = ROW_CMP_W'(MAX_ROWS);
        end else begin
            rows_eff = rows_ext;
        end
        rows_last = rows_eff - ROW_CMP_W'(1);

        cols_ext = COL_CMP_W'(r_grid_cols);
        if (cols_ext == '0) begin
            cols_eff = COL_CMP_W'(1);
        end else if (cols_ext > COL_CMP_W'(MAX_COLS)) begin
            cols_eff = COL_CMP_W'(MAX_COLS);
        end else begin
            cols_eff = cols_ext;
        end
        cols_last = cols_eff - COL_CMP_W'(1);
        ins_pos   = COL_CMP_W'(MAX_COLS) - cols_eff;
    end

    assign row_is_last = (ROW_CMP_W'(r_row) == rows_last);
    assign col_is_last = (COL_CMP_W'(r_col) == cols_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= CFG_ROWS_RESET;
            r_grid_cols <= CFG_COLS_RESET;
            r_row       <= '0;
            r_col       <= '0;
            r_w1        <= '0;
            r_w2        <= '0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_IDX_ROWS: begin
                    r_grid_rows <= i_cfg_data[CFG_ROWS_W-1:0];
                end
                CFG_IDX_COLS: begin
                    r_grid_cols <= i_cfg_data[CFG_COLS_W-1:0];
                end
                default: begin
                end
            endcase
            r_row <= '0;
            r_col <= '0;
            r_w1  <= '0;
            r_w2  <= '0;
        end else if (in_acc) begin
            r_w1 <= r_w2;
            r_w2 <= {tile_cur, up1, up2};
            if (col_is_last) begin
                r_col <= '0;
                r_row <= row_is_last ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // The row store chain: a tile written at a slot leaves the far end one row later.
    assign tile_cur = i_tile_in;
    assign up2      = chain[MAX_COLS-1].older;
    assign up1      = chain[MAX_COLS-1].newer;
    assign line_ins = '{older: up1, newer: tile_cur};

    for (genvar k = 0; k < MAX_COLS; k++) begin : g_cell
        assign ins_sel[k] = (COL_CMP_W'(k) == ins_pos);
        if (k == 0) begin : g_first
            csa_line_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (in_acc),
                .i_load  (ins_sel[k]),
                .i_prev  (line_ins),
                .i_ins   (line_ins),
                .o_q     (chain[k])
            );
        end else begin : g_next
            csa_line_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (in_acc),
                .i_load  (ins_sel[k]),
                .i_prev  (chain[k-1]),
                .i_ins   (line_ins),
                .o_q     (chain[k])
            );
        end
    end

    always_comb begin
        center = r_w2[1];
        nb[0]  = r_w1[0];
        nb[1]  = r_w1[1];
        nb[2]  = r_w1[2];
        nb[3]  = r_w2[0];
        nb[4]  = r_w2[2];
        nb[5]  = up2;
        nb[6]  = up1;
        nb[7]  = tile_cur;
        walls    = '0;
        any_void = 1'b0;
        for (int k = 0; k < 8; k++) begin
            walls    = walls + WALL_CNT_W'(nb[k] == TILE_WALL);
            any_void = any_void || (nb[k] == TILE_VOID);
        end
        on_border = (r_row == ROW_W'(1)) || (r_col == COL_W'(1));
        if (center == TILE_VOID) begin
            smooth_tile = TILE_VOID;
        end else if (on_border || any_void || (walls >= WALL_LIMIT)) begin
            smooth_tile = TILE_WALL;
        end else begin
            smooth_tile = TILE_GROUND;
        end
    end

    always_comb begin
        logic [PUSH_N_W-1:0] idx;
        row_wide_cur = {{OUT_ROW_W{1'b0}}, r_row};
        row_wide_m1  = {{OUT_ROW_W{1'b0}}, r_row - ROW_W'(1)};
        col_wide_cur = {{OUT_COL_W{1'b0}}, r_col};
        col_wide_m1  = {{OUT_COL_W{1'b0}}, r_col - COL_W'(1)};

        f1 = (r_row != '0) && (r_col != '0);
        f2 = (r_row != '0) && col_is_last;
        f3 = row_is_last;

        res1.row  = row_wide_m1[OUT_ROW_W-1:0];
        res1.col  = col_wide_m1[OUT_COL_W-1:0];
        res1.tile = smooth_tile;
        res1.last = !f2 && !f3;

        res2.row  = row_wide_m1[OUT_ROW_W-1:0];
        res2.col  = col_wide_cur[OUT_COL_W-1:0];
        res2.tile = (up1 == TILE_VOID) ? TILE_VOID : TILE_WALL;
        res2.last = !f3;

        res3.row  = row_wide_cur[OUT_ROW_W-1:0];
        res3.col  = col_wide_cur[OUT_COL_W-1:0];
        res3.tile = (tile_cur == TILE_VOID) ? TILE_VOID : TILE_WALL;
        res3.last = 1'b1;

        push.ent = '0;
        idx      = '0;
        if (f1) begin
            push.ent[idx] = res1;
            idx = idx + PUSH_N_W'(1);
        end
        if (f2) begin
            push.ent[idx] = res2;
            idx = idx + PUSH_N_W'(1);
        end
        if (f3) begin
            push.ent[idx] = res3;
            idx = idx + PUSH_N_W'(1);
        end
        push.n = in_acc ? idx : '0;
    end

    csa_result_fifo u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_pop     (!i_stall),
        .o_valid   (o_valid),
        .o_no_room (no_room),
        .o_head    (head)
    );

    assign o_out_row  = head.row;
    assign o_out_col  = head.col;
    assign o_tile_out = head.tile;
    assign o_run_last = head.last;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        COL_CMP_W'(r_col) <= cols_last)
        else $error("Column counter is beyond the last column.");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ROW_CMP_W'(r_row) <= rows_last)
        else $error("Row counter is beyond the last row.");

    a_row_end_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && col_is_last && (r_row != '0) && (r_col != '0)) |-> (push.n >= 2'd2))
        else $error("A transaction at the end of a row lost a result.");

    a_empty_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("Input stalls while the result queue is empty.");

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for cave_smoothing_automaton_step_core, one smoothing generation.
// A queue-fed driver and a checking monitor run against an in-bench smoothing predictor.
// Depends on csa_pkg and the core RTL.
`timescale 1ns / 1ps

module tb
    import csa_pkg::*;
();

    localparam int GRID_MAX_COLS = 64;
    localparam int GRID_MAX_ROWS = 4096;
    localparam t_tile TILE_SPARE = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [TILE_W-1:0]     i_tile_in = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [OUT_ROW_W-1:0]  o_out_row;
    logic [OUT_COL_W-1:0]  o_out_col;
    logic [TILE_W-1:0]     o_tile_out;
    logic                  o_run_last;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    cave_smoothing_automaton_step_core #(
        .MAX_COLS(GRID_MAX_COLS),
        .MAX_ROWS(GRID_MAX_ROWS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_tile_in(i_tile_in),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_out_row(o_out_row),
        .o_out_col(o_out_col),
        .o_tile_out(o_tile_out),
        .o_run_last(o_run_last),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_tile       pending_tiles[$];
    t_result     smoothed_q[$];
    int unsigned tiles_queued = 0;
    int unsigned tiles_taken = 0;
    int unsigned results_seen = 0;
    int unsigned fail_count = 0;
    int unsigned stall_pct = 0;
    bit          sender_gaps = 1'b0;

    logic [CFG_ROWS_W-1:0] rows_reg;
    logic [CFG_COLS_W-1:0] cols_reg;
    t_tile       older_line [GRID_MAX_COLS];
    t_tile       newer_line [GRID_MAX_COLS];
    t_tile       win [3][3];
    int unsigned cur_row;
    int unsigned cur_col;

    function automatic int unsigned eff_size(int unsigned v, int unsigned lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic t_tile border_value(t_tile t);
        return (t == TILE_VOID) ? TILE_VOID : TILE_WALL;
    endfunction

    function automatic t_tile smooth_center(bit on_border);
        int unsigned walls = 0;
        if (win[1][1] == TILE_VOID) return TILE_VOID;
        if (on_border) return TILE_WALL;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (!(i == 1 && j == 1)) begin
                    if (win[i][j] == TILE_VOID) return TILE_WALL;
                    if (win[i][j] == TILE_WALL) walls++;
                end
            end
        end
        return (walls < WALL_LIMIT) ? TILE_GROUND : TILE_WALL;
    endfunction

    function automatic t_result make_result(int unsigned row, int unsigned col, t_tile t);
        t_result res;
        res.row  = OUT_ROW_W'(row);
        res.col  = OUT_COL_W'(col);
        res.tile = t;
        res.last = 1'b0;
        return res;
    endfunction

    function automatic void restart_frame();
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                win[i][j] = TILE_GROUND;
            end
        end
        cur_row = 0;
        cur_col = 0;
    endfunction

    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_IDX_ROWS) begin
            rows_reg = data[CFG_ROWS_W-1:0];
        end else begin
            cols_reg = data[CFG_COLS_W-1:0];
        end
        restart_frame();
    endfunction

    function automatic void predict_smoothing(t_tile t);
        int unsigned nrows;
        int unsigned ncols;
        int unsigned r;
        int unsigned c;
        t_tile       up_old;
        t_tile       up_new;
        t_result     res [3];
        int          n;
        nrows = eff_size(rows_reg, GRID_MAX_ROWS);
        ncols = eff_size(cols_reg, GRID_MAX_COLS);
        r = cur_row;
        c = cur_col;
        n = 0;
        if (r >= nrows || c >= ncols) begin
            r = 0;
            c = 0;
        end
        up_old = older_line[c];
        up_new = newer_line[c];
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = up_old;
        win[1][2] = up_new;
        win[2][2] = t;
        older_line[c] = up_new;
        newer_line[c] = t;
        if (r >= 1 && c >= 1) begin
            res[n] = make_result(r - 1, c - 1, smooth_center(r == 1 || c == 1));
            n++;
        end
        if (r >= 1 && c == ncols - 1) begin
            res[n] = make_result(r - 1, c, border_value(up_new));
            n++;
        end
        if (r == nrows - 1) begin
            res[n] = make_result(r, c, border_value(t));
            n++;
        end
        if (n > 0) res[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) smoothed_q.push_back(res[k]);
        c++;
        if (c >= ncols) begin
            c = 0;
            r++;
            if (r >= nrows) r = 0;
        end
        cur_row = r;
        cur_col = c;
    endfunction

    int unsigned burst_left = 1;
    int unsigned gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_smoothing(i_tile_in);
                tiles_taken++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_tiles.size() > 0) begin
                    i_valid   <= 1'b1;
                    i_tile_in <= pending_tiles.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = sender_gaps ? $urandom_range(0, 5) : 0;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    t_result     exp_res;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (smoothed_q.size() == 0) begin
                    $display("%0t: unexpected result row %0d col %0d tile %0d last %0d",
                             $time, o_out_row, o_out_col, o_tile_out, o_run_last);
                    fail_count++;
                end else begin
                    exp_res = smoothed_q.pop_front();
                    if (o_out_row !== exp_res.row) begin
                        $display("%0t: out_row expected %0d actual %0d",
                                 $time, exp_res.row, o_out_row);
                        fail_count++;
                    end
                    if (o_out_col !== exp_res.col) begin
                        $display("%0t: out_col expected %0d actual %0d",
                                 $time, exp_res.col, o_out_col);
                        fail_count++;
                    end
                    if (o_tile_out !== exp_res.tile) begin
                        $display("%0t: tile_out expected %0d actual %0d",
                                 $time, exp_res.tile, o_tile_out);
                        fail_count++;
                    end
                    if (o_run_last !== exp_res.last) begin
                        $display("%0t: run_last expected %0d actual %0d",
                                 $time, exp_res.last, o_run_last);
                        fail_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!hold_done && results_seen >= 40 && pending_tiles.size() >= 30) begin
                hold_done = 1'b1;
                hold_left = 200;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        apply_cfg(idx, data);
    endtask

    task automatic drain();
        while (tiles_taken != tiles_queued || smoothed_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic push_tile(input t_tile t);
        pending_tiles.push_back(t);
        tiles_queued++;
    endtask

    task automatic queue_random_tiles(input int unsigned n, input int unsigned wall_pct);
        int unsigned roll;
        for (int unsigned k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) push_tile(TILE_VOID);
            else if (roll < 8) push_tile(TILE_SPARE);
            else push_tile(($urandom_range(0, 99) < wall_pct) ? TILE_WALL : TILE_GROUND);
        end
    endtask

    task automatic pick_idling();
        int unsigned mode;
        mode = $urandom_range(0, 4);
        case (mode)
            0: begin
                stall_pct = 0;
                sender_gaps = 1'b0;
            end
            1: stall_pct = 10;
            2: stall_pct = 30;
            3: stall_pct = 60;
            default: stall_pct = 0;
        endcase
        if (mode != 0) sender_gaps = $urandom_range(0, 1);
    endtask

    int unsigned random_items;
    int unsigned nrows_pick;
    int unsigned ncols_pick;
    int unsigned count;

    initial begin
        rows_reg = CFG_ROWS_RESET;
        cols_reg = CFG_COLS_RESET;
        for (int k = 0; k < GRID_MAX_COLS; k++) begin
            older_line[k] = TILE_GROUND;
            newer_line[k] = TILE_GROUND;
        end
        restart_frame();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        stall_pct = 20;
        sender_gaps = 1'b1;
        queue_random_tiles(70, 45);
        drain();

        write_reg(CFG_IDX_ROWS, 13'd3);
        write_reg(CFG_IDX_COLS, 13'h1F83);
        push_tile(TILE_WALL);  push_tile(TILE_WALL);   push_tile(TILE_WALL);
        push_tile(TILE_WALL);  push_tile(TILE_SPARE);  push_tile(TILE_GROUND);
        push_tile(TILE_GROUND); push_tile(TILE_GROUND); push_tile(TILE_VOID);
        push_tile(TILE_SPARE); push_tile(TILE_WALL);   push_tile(TILE_WALL);
        push_tile(TILE_WALL);  push_tile(TILE_GROUND); push_tile(TILE_SPARE);
        push_tile(TILE_GROUND); push_tile(TILE_VOID);  push_tile(TILE_GROUND);
        drain();

        write_reg(CFG_IDX_ROWS, 13'd0);
        write_reg(CFG_IDX_COLS, 13'd0);
        push_tile(TILE_VOID);
        push_tile(TILE_SPARE);
        drain();

        write_reg(CFG_IDX_ROWS, 13'h1FFF);
        write_reg(CFG_IDX_COLS, 13'd127);
        push_tile(TILE_GROUND);
        push_tile(TILE_WALL);
        push_tile(TILE_VOID);
        drain();

        write_reg(CFG_IDX_ROWS, 13'd2);
        write_reg(CFG_IDX_COLS, 13'd64);
        pick_idling();
        queue_random_tiles(128, 45);
        random_items = 128;
        drain();

        while (random_items < 180) begin
            if ($urandom_range(0, 4) == 0) begin
                ncols_pick = $urandom_range(17, 64);
                nrows_pick = $urandom_range(1, 3);
            end else begin
                ncols_pick = $urandom_range(1, 12);
                nrows_pick = $urandom_range(1, 8);
            end
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_IDX_ROWS, CFG_DATA_W'(nrows_pick));
                write_reg(CFG_IDX_COLS, {6'($urandom_range(0, 63)), 7'(ncols_pick)});
            end else begin
                write_reg(CFG_IDX_COLS, {6'($urandom_range(0, 63)), 7'(ncols_pick)});
                write_reg(CFG_IDX_ROWS, CFG_DATA_W'(nrows_pick));
            end
            if ($urandom_range(0, 3) == 0)
                count = $urandom_range(1, nrows_pick * ncols_pick);
            else
                count = nrows_pick * ncols_pick * $urandom_range(1, 2);
            if (count > 24) count = 24;
            if (count > 180 - random_items) count = 180 - random_items;
            pick_idling();
            queue_random_tiles(count, $urandom_range(30, 60));
            random_items += count;
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
hdl/csa_pkg.sv
hdl/csa_line_cell.sv
hdl/csa_result_fifo.sv
hdl/cave_smoothing_automaton_step_core.sv
sim/tb.sv
